>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with no disable (holds during reset too).
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lobm_pkg.sv
`timescale 1ns / 1ps

package lobm_pkg;

    // Result status codes
    localparam logic [2:0] STAT_RESTED    = 3'd0;
    localparam logic [2:0] STAT_TRADED    = 3'd1;
    localparam logic [2:0] STAT_REJECTED  = 3'd2;
    localparam logic [2:0] STAT_CANCELLED = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND  = 3'd4;
    localparam logic [2:0] STAT_FULL      = 3'd5;

    // Request modes
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_CANCEL = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_FIND,
        ST_FIND_TAIL,
        ST_REC_RD,
        ST_CAN_SET,
        ST_LVL_RD,
        ST_LVL_WR,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_DONE
    } state_t;

    // What the level read-modify-write does
    typedef enum logic [1:0] {
        OP_REST,
        OP_TRADE,
        OP_CANCEL
    } op_kind_t;

    // Stored order record (valid bit kept in flops)
    typedef struct packed {
        logic        buy;
        logic [9:0]  price;
        logic [23:0] qty;
    } rec_t;

endpackage

>>> rtl/limit_order_book_matcher_unit.sv
`timescale 1ns / 1ps

// Price-level limit order book. Pulse start with an add or cancel request while
// busy is low; exactly one result word follows, shown for a single cycle with
// done high, and it must be captured then since the receiver cannot stall the
// block. After reset the level tables are cleared one entry a cycle, and busy
// stays high, and no request is taken, until all PRICE_LEVELS entries are
// cleared. One sequencer drives a single compare/add/subtract unit and one read
// port per table. A rejected add goes from decode straight to done; a resting
// add searches the order slots one per cycle and then updates its level; a
// crossing add does one level update and then rescans both level tables from
// the outside in; a cancel does the slot search, the level update and the rescan.
module limit_order_book_matcher_unit #(
    parameter int PRICE_LEVELS = 1024,
    parameter int ORDER_SLOTS  = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [31:0]        order_id,
    input  logic [9:0]         price_tick,
    input  logic [23:0]        quantity,
    input  logic               is_buy,
    output logic               done,
    output logic [2:0]         status,
    output logic [9:0]         exec_price,
    output logic [23:0]        exec_qty,
    output logic [9:0]         best_bid,
    output logic               bid_present,
    output logic [9:0]         best_ask,
    output logic               ask_present,
    output logic signed [10:0] spread
);
    import lobm_pkg::*;

    `include "assert_macros.svh"

    localparam int LW = $clog2(PRICE_LEVELS);
    localparam int SW = $clog2(ORDER_SLOTS);
    localparam logic [LW-1:0] LVL_LAST  = LW'(PRICE_LEVELS - 1);
    localparam logic [LW-1:0] SCAN_LAST = LW'(PRICE_LEVELS - 2);
    localparam logic [SW-1:0] SLOT_LAST = SW'(ORDER_SLOTS - 1);

    // Memories
    logic [31:0] bid_mem [PRICE_LEVELS];
    logic [31:0] ask_mem [PRICE_LEVELS];
    logic [31:0] id_mem  [ORDER_SLOTS];
    rec_t        rec_mem [ORDER_SLOTS];

    state_t state_reg, state_next;
    op_kind_t op_reg, op_next;

    // Request word
    logic        mode_reg;
    logic [31:0] id_reg;
    logic [9:0]  price_reg;
    logic [23:0] qty_reg;
    logic        buy_reg;

    // Result and book state
    logic [2:0]  status_reg, status_next;
    logic [9:0]  ex_price_reg, ex_price_next;
    logic [23:0] ex_qty_reg, ex_qty_next;
    logic [9:0]  best_bid_reg, best_bid_next;
    logic        bid_pres_reg, bid_pres_next;
    logic [9:0]  best_ask_reg, best_ask_next;
    logic        ask_pres_reg, ask_pres_next;

    // Counters and work registers
    logic [LW-1:0] lvl_cnt_reg, lvl_cnt_next;
    logic [SW-1:0] slot_cnt_reg, slot_cnt_next;
    logic [SW-1:0] slot_chk_reg;
    logic [SW-1:0] slot_idx_reg, slot_idx_next;
    logic [SW-1:0] free_idx_reg, free_idx_next;
    logic          free_found_reg, free_found_next;
    logic          chk_vld_reg;
    logic          work_buy_reg, work_buy_next;
    logic [LW-1:0] work_addr_reg, work_addr_next;
    logic [23:0]   work_qty_reg, work_qty_next;
    logic [ORDER_SLOTS-1:0] valid_reg;

    // Memory ports
    logic [LW-1:0] bid_raddr, ask_raddr;
    logic [LW-1:0] bid_chk_reg, ask_chk_reg;
    logic [31:0]   bid_rdata_reg, ask_rdata_reg, id_rdata_reg;
    rec_t          rec_rdata_reg;
    logic          bid_we, ask_we;
    logic [LW-1:0] lvl_waddr;
    logic [31:0]   lvl_wdata;
    logic          slot_we;
    logic [SW-1:0] slot_waddr;
    logic          valid_set, valid_clr;

    // Datapath terms
    logic [31:0] lvl_val;
    logic [32:0] lvl_sum;
    logic [31:0] trade_q;
    logic        bid_hit, ask_hit, slot_hit, slot_free;
    logic [SW-1:0] free_eff;
    logic        bad_add;

    // Level tables: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (bid_we)
        begin
            bid_mem[lvl_waddr] <= lvl_wdata;
        end
        if (ask_we)
        begin
            ask_mem[lvl_waddr] <= lvl_wdata;
        end
        bid_rdata_reg <= bid_mem[bid_raddr];
        ask_rdata_reg <= ask_mem[ask_raddr];
        bid_chk_reg   <= bid_raddr;
        ask_chk_reg   <= ask_raddr;
    end

    // Order slot tables
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            id_mem[slot_waddr]  <= id_reg;
            rec_mem[slot_waddr] <= '{buy: buy_reg, price: price_reg, qty: qty_reg};
        end
        id_rdata_reg  <= id_mem[slot_cnt_reg];
        slot_chk_reg  <= slot_cnt_reg;
        rec_rdata_reg <= rec_mem[slot_idx_reg];
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg  <= mode;
            id_reg    <= order_id;
            price_reg <= price_tick;
            qty_reg   <= quantity;
            buy_reg   <= is_buy;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            op_reg         <= OP_REST;
            status_reg     <= STAT_RESTED;
            ex_price_reg   <= '0;
            ex_qty_reg     <= '0;
            best_bid_reg   <= '0;
            bid_pres_reg   <= 1'b0;
            best_ask_reg   <= '0;
            ask_pres_reg   <= 1'b0;
            lvl_cnt_reg    <= '0;
            slot_cnt_reg   <= '0;
            slot_idx_reg   <= '0;
            free_idx_reg   <= '0;
            free_found_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            work_buy_reg   <= 1'b0;
            work_addr_reg  <= '0;
            work_qty_reg   <= '0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            status_reg     <= status_next;
            ex_price_reg   <= ex_price_next;
            ex_qty_reg     <= ex_qty_next;
            best_bid_reg   <= best_bid_next;
            bid_pres_reg   <= bid_pres_next;
            best_ask_reg   <= best_ask_next;
            ask_pres_reg   <= ask_pres_next;
            lvl_cnt_reg    <= lvl_cnt_next;
            slot_cnt_reg   <= slot_cnt_next;
            slot_idx_reg   <= slot_idx_next;
            free_idx_reg   <= free_idx_next;
            free_found_reg <= free_found_next;
            chk_vld_reg    <= (state_reg == ST_SCAN) || (state_reg == ST_FIND);
            work_buy_reg   <= work_buy_next;
            work_addr_reg  <= work_addr_next;
            work_qty_reg   <= work_qty_next;
            if (valid_set)
            begin
                valid_reg[slot_waddr] <= 1'b1;
            end
            if (valid_clr)
            begin
                valid_reg[slot_idx_reg] <= 1'b0;
            end
        end
    end

    // Shared compare / add unit terms
    assign lvl_val   = work_buy_reg ? bid_rdata_reg : ask_rdata_reg;
    assign lvl_sum   = {1'b0, lvl_val} + 33'(work_qty_reg);
    assign trade_q   = (32'(work_qty_reg) < lvl_val) ? 32'(work_qty_reg) : lvl_val;
    assign bid_hit   = chk_vld_reg && !bid_pres_reg && (bid_rdata_reg != '0);
    assign ask_hit   = chk_vld_reg && !ask_pres_reg && (ask_rdata_reg != '0);
    assign slot_hit  = chk_vld_reg && valid_reg[slot_chk_reg] && (id_rdata_reg == id_reg);
    assign slot_free = chk_vld_reg && !valid_reg[slot_chk_reg];
    assign free_eff  = free_found_reg ? free_idx_reg : slot_chk_reg;
    assign bad_add   = (price_reg == '0) || (qty_reg == '0)
                     || (32'(price_reg) >= 32'(PRICE_LEVELS));

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        ex_price_next   = ex_price_reg;
        ex_qty_next     = ex_qty_reg;
        best_bid_next   = best_bid_reg;
        bid_pres_next   = bid_pres_reg;
        best_ask_next   = best_ask_reg;
        ask_pres_next   = ask_pres_reg;
        lvl_cnt_next    = lvl_cnt_reg;
        slot_cnt_next   = slot_cnt_reg;
        slot_idx_next   = slot_idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        work_buy_next   = work_buy_reg;
        work_addr_next  = work_addr_reg;
        work_qty_next   = work_qty_reg;
        bid_raddr       = work_addr_reg;
        ask_raddr       = work_addr_reg;
        bid_we          = 1'b0;
        ask_we          = 1'b0;
        lvl_waddr       = work_addr_reg;
        lvl_wdata       = '0;
        slot_we         = 1'b0;
        slot_waddr      = free_eff;
        valid_set       = 1'b0;
        valid_clr       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                bid_we    = 1'b1;
                ask_we    = 1'b1;
                lvl_waddr = lvl_cnt_reg;
                if (lvl_cnt_reg == LVL_LAST)
                begin
                    lvl_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    lvl_cnt_next = lvl_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    ex_price_next = '0;
                    ex_qty_next   = '0;
                    state_next    = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                slot_cnt_next   = '0;
                free_found_next = 1'b0;
                work_qty_next   = qty_reg;
                if (mode_reg == MODE_CANCEL)
                begin
                    op_next     = OP_CANCEL;
                    status_next = STAT_CANCELLED;
                    state_next  = ST_FIND;
                end
                else if (bad_add)
                begin
                    status_next = STAT_REJECTED;
                    state_next  = ST_DONE;
                end
                else if (buy_reg && ask_pres_reg && (price_reg >= best_ask_reg))
                begin
                    op_next        = OP_TRADE;
                    status_next    = STAT_TRADED;
                    ex_price_next  = best_ask_reg;
                    work_buy_next  = 1'b0;
                    work_addr_next = LW'(best_ask_reg);
                    state_next     = ST_LVL_RD;
                end
                else if (!buy_reg && bid_pres_reg && (price_reg <= best_bid_reg))
                begin
                    op_next        = OP_TRADE;
                    status_next    = STAT_TRADED;
                    ex_price_next  = best_bid_reg;
                    work_buy_next  = 1'b1;
                    work_addr_next = LW'(best_bid_reg);
                    state_next     = ST_LVL_RD;
                end
                else
                begin
                    op_next        = OP_REST;
                    status_next    = STAT_RESTED;
                    work_buy_next  = buy_reg;
                    work_addr_next = LW'(price_reg);
                    state_next     = ST_FIND;
                end
            end

            // Slot search: id read issued from slot_cnt, checked in the next cycle
            ST_FIND, ST_FIND_TAIL:
            begin
                if (slot_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = slot_chk_reg;
                end
                if (slot_hit)
                begin
                    slot_idx_next = slot_chk_reg;
                    state_next    = (op_reg == OP_CANCEL) ? ST_REC_RD : ST_LVL_RD;
                end
                else if (state_reg == ST_FIND)
                begin
                    if (slot_cnt_reg == SLOT_LAST)
                    begin
                        state_next = ST_FIND_TAIL;
                    end
                    else
                    begin
                        slot_cnt_next = slot_cnt_reg + 1'b1;
                    end
                end
                else if (op_reg == OP_CANCEL)
                begin
                    status_next = STAT_NOTFOUND;
                    state_next  = ST_DONE;
                end
                else if (free_found_reg || slot_free)
                begin
                    slot_we    = 1'b1;
                    valid_set  = 1'b1;
                    state_next = ST_LVL_RD;
                end
                else
                begin
                    status_next = STAT_FULL;
                    state_next  = ST_DONE;
                end
            end

            ST_REC_RD:
            begin
                state_next = ST_CAN_SET;
            end

            ST_CAN_SET:
            begin
                work_buy_next  = rec_rdata_reg.buy;
                work_addr_next = LW'(rec_rdata_reg.price);
                work_qty_next  = rec_rdata_reg.qty;
                state_next     = ST_LVL_RD;
            end

            ST_LVL_RD:
            begin
                state_next = ST_LVL_WR;
            end

            // Read-modify-write of one level through the shared unit
            ST_LVL_WR:
            begin
                bid_we = work_buy_reg;
                ask_we = !work_buy_reg;
                unique case (op_reg)
                    OP_REST:
                    begin
                        lvl_wdata  = lvl_sum[32] ? '1 : lvl_sum[31:0];
                        state_next = ST_DONE;
                        if (work_buy_reg)
                        begin
                            if (!bid_pres_reg || (price_reg > best_bid_reg))
                            begin
                                bid_pres_next = 1'b1;
                                best_bid_next = price_reg;
                            end
                        end
                        else if (!ask_pres_reg || (price_reg < best_ask_reg))
                        begin
                            ask_pres_next = 1'b1;
                            best_ask_next = price_reg;
                        end
                    end
                    OP_TRADE:
                    begin
                        lvl_wdata   = lvl_val - trade_q;
                        ex_qty_next = trade_q[23:0];
                        state_next  = ST_SCAN;
                    end
                    default:
                    begin
                        lvl_wdata  = (lvl_val > 32'(work_qty_reg))
                                   ? lvl_val - 32'(work_qty_reg) : '0;
                        valid_clr  = 1'b1;
                        state_next = ST_SCAN;
                    end
                endcase
                if (state_next == ST_SCAN)
                begin
                    lvl_cnt_next  = '0;
                    best_bid_next = '0;
                    bid_pres_next = 1'b0;
                    best_ask_next = '0;
                    ask_pres_next = 1'b0;
                end
            end

            // Rescan: bids from the top down, asks from tick 1 up
            ST_SCAN, ST_SCAN_TAIL:
            begin
                bid_raddr = LVL_LAST - lvl_cnt_reg;
                ask_raddr = lvl_cnt_reg + 1'b1;
                if (bid_hit)
                begin
                    bid_pres_next = 1'b1;
                    best_bid_next = 10'(bid_chk_reg);
                end
                if (ask_hit)
                begin
                    ask_pres_next = 1'b1;
                    best_ask_next = 10'(ask_chk_reg);
                end
                if ((state_reg == ST_SCAN_TAIL)
                    || ((bid_pres_reg || bid_hit) && (ask_pres_reg || ask_hit)))
                begin
                    state_next = ST_DONE;
                end
                else if (lvl_cnt_reg == SCAN_LAST)
                begin
                    state_next = ST_SCAN_TAIL;
                end
                else
                begin
                    lvl_cnt_next = lvl_cnt_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result word
    assign busy        = (state_reg != ST_IDLE);
    assign done        = (state_reg == ST_DONE);
    assign status      = status_reg;
    assign exec_price  = ex_price_reg;
    assign exec_qty    = ex_qty_reg;
    assign best_bid    = best_bid_reg;
    assign bid_present = bid_pres_reg;
    assign best_ask    = best_ask_reg;
    assign ask_present = ask_pres_reg;
    assign spread      = (bid_pres_reg && ask_pres_reg)
                       ? ($signed({1'b0, best_ask_reg}) - $signed({1'b0, best_bid_reg}))
                       : -11'sd1;

    // Checks
    `ASSERT_CLK(a_start_goes_busy, (start && !busy) |=> busy, "request not taken")
    `ASSERT_CLK(a_done_single, done |=> !done, "result shown twice")
    `ASSERT_CLK(a_exec_only_trade,
        (done && (status != STAT_TRADED)) |-> ((exec_qty == '0) && (exec_price == '0)),
        "execution fields set without a trade")
    `ASSERT_ALWAYS(a_bid_empty_zero, !bid_present |-> (best_bid == '0), "stale best bid")
endmodule
